@@ design/stepped_probe_slot_table_unit_assert.svh @@
// Assertion macros for the checker file of the slot table.
`ifndef STEPPED_PROBE_SLOT_TABLE_UNIT_ASSERT_SVH
`define STEPPED_PROBE_SLOT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define SPST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define SPST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/spst_pkg.sv @@
package spst_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEFAULT_SLOT_COUNT = 64;
  localparam int DEFAULT_KEY_BITS   = 64;

  // The slot index fields are six bits, so at most 64 slots are ever active.
  localparam int MAX_ACTIVE = 64;
  localparam int CFG_W      = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Stream payload layout.
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_USED_W  = 9;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DROPPED  = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_CLEARED  = 3'd3;
  localparam logic [2:0] ST_MATCH    = 3'd4;
  localparam logic [2:0] ST_NOMATCH  = 3'd5;
  localparam logic [2:0] ST_BADINDEX = 3'd6;
  localparam logic [2:0] ST_UNUSED   = 3'd7;

endpackage

@@ design/spst_key_ram.sv @@
module spst_key_ram #(
  parameter int DEPTH = spst_pkg::DEFAULT_SLOT_COUNT,
  parameter int WIDTH = spst_pkg::DEFAULT_KEY_BITS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port, single registered read port; read data holds
  // until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/stepped_probe_slot_table_unit.sv @@
// Channel   Direction  Ports                              Payload
// in_       slave      in_tvalid/in_tready/in_tdata      opcode, home_index, probe_step, key
// out_      master     out_tvalid/out_tready/out_tdata   status, slot_index; tlast = last
// cfg_      write      cfg_wr_en/cfg_wr_data             slots_in_use
//
// One item is worked on at a time; in_tready is high only while the sequencer is idle.
// Remove and clear finish from the execute state; insert probes the valid bits slot by slot.
// Find scans every active slot, since each slot needs a key RAM read and then a compare
// in the shared comparator.
// rst_n (synchronous, active low) empties every slot and sets slots_in_use to 64.
// A result waits in the output register; while it is not taken the sequencer stalls.
module stepped_probe_slot_table_unit #(
  parameter int SLOT_COUNT = spst_pkg::DEFAULT_SLOT_COUNT,
  parameter int KEY_BITS   = spst_pkg::DEFAULT_KEY_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode [1:0], home_index [7:2], probe_step [13:8], key_value [77:14], zero [79:78]
  input  logic [spst_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status [2:0], slot_index [8:3], zero [15:9]
  output logic [spst_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  input  logic                              cfg_wr_en,
  input  logic [spst_pkg::CFG_W-1:0]        cfg_wr_data
);

  // Only the first 64 slots can ever be addressed, so storage stops there.
  localparam int DEPTH = (SLOT_COUNT < spst_pkg::MAX_ACTIVE) ? SLOT_COUNT
                                                              : spst_pkg::MAX_ACTIVE;
  localparam int IDXW = $clog2(DEPTH);
  localparam logic [spst_pkg::CFG_W-1:0] DEPTH_W = spst_pkg::CFG_W'(DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [1:0]                 op_r;
  logic [5:0]                 home_r;
  logic [5:0]                 step_r;
  logic [KEY_BITS-1:0]        key_r;
  logic [6:0]                 idx_r, idx_nxt;
  logic                       pend_r, pend_nxt;
  logic [5:0]                 pend_idx_r, pend_idx_nxt;
  logic [5:0]                 cmp_idx_r, cmp_idx_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic [DEPTH-1:0]           valid_r, valid_nxt;
  logic [spst_pkg::CFG_W-1:0] slots_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [2:0]                 out_status_r, out_status_nxt;
  logic [5:0]                 out_slot_r, out_slot_nxt;
  logic                       out_last_r, out_last_nxt;

  logic [spst_pkg::CFG_W-1:0] n_act;
  logic                       in_accept;
  logic                       out_free;
  logic                       idx_in;
  logic                       home_in;
  logic                       valid_at_idx;
  logic                       key_hit;
  logic                       mem_we;
  logic                       mem_re;
  logic [KEY_BITS-1:0]        rd_key;

  // Active slot count, saturated at the storage depth.
  assign n_act     = (slots_r > DEPTH_W) ? DEPTH_W : slots_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  // The output register can take a new result when it is empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign idx_in    = (idx_r < n_act);
  assign home_in   = ({1'b0, home_r} < n_act);
  // Only looked at when idx_in holds, so the index is always in range then.
  assign valid_at_idx = idx_in && valid_r[idx_r[IDXW-1:0]];
  // The shared comparator: the slot key just read against the search key.
  assign key_hit = cmp_vld_r && (rd_key == key_r);

  spst_key_ram #(
    .DEPTH (DEPTH),
    .WIDTH (KEY_BITS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (idx_r[IDXW-1:0]),
    .wr_data (key_r),
    .rd_en   (mem_re),
    .rd_addr (idx_r[IDXW-1:0]),
    .rd_data (rd_key)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (op_r)
          spst_pkg::OP_INSERT: begin
            if (!home_in) begin
              if (out_free) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = spst_pkg::ST_BADINDEX;
                out_slot_nxt   = home_r;
                out_last_nxt   = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else begin
              idx_nxt   = {1'b0, home_r};
              state_nxt = S_PROBE;
            end
          end
          spst_pkg::OP_REMOVE: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_slot_nxt  = home_r;
              out_last_nxt  = 1'b1;
              state_nxt     = S_IDLE;
              if (!home_in) begin
                out_status_nxt = spst_pkg::ST_BADINDEX;
              end else begin
                out_status_nxt = spst_pkg::ST_REMOVED;
                valid_nxt[home_r[IDXW-1:0]] = 1'b0;
              end
            end
          end
          spst_pkg::OP_CLEAR: begin
            if (out_free) begin
              valid_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = spst_pkg::ST_CLEARED;
              out_slot_nxt   = 6'd0;
              out_last_nxt   = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
          default: begin
            idx_nxt   = 7'd0;
            pend_nxt  = 1'b0;
            state_nxt = S_READ;
          end
        endcase
      end

      // One probe per cycle on the valid bits; the key is written on the free slot.
      S_PROBE: begin
        if (!idx_in || (valid_at_idx && (step_r == 6'd0))) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = spst_pkg::ST_DROPPED;
            out_slot_nxt   = 6'd0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else if (valid_at_idx) begin
          idx_nxt = idx_r + {1'b0, step_r};
        end else if (out_free) begin
          mem_we                     = 1'b1;
          valid_nxt[idx_r[IDXW-1:0]] = 1'b1;
          out_valid_nxt              = 1'b1;
          out_status_nxt             = spst_pkg::ST_STORED;
          out_slot_nxt               = idx_r[5:0];
          out_last_nxt               = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end

      // Issue the key read for the current slot, or close the scan.
      S_READ: begin
        if (!idx_in) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pend_r ? spst_pkg::ST_MATCH : spst_pkg::ST_NOMATCH;
            out_slot_nxt   = pend_r ? pend_idx_r : 6'd0;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end
        end else begin
          mem_re      = 1'b1;
          cmp_vld_nxt = valid_at_idx;
          cmp_idx_nxt = idx_r[5:0];
          state_nxt   = S_CMP;
        end
      end

      // A match is held back one step so that the final one can carry tlast.
      S_CMP: begin
        if (key_hit && pend_r) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = spst_pkg::ST_MATCH;
            out_slot_nxt   = pend_idx_r;
            out_last_nxt   = 1'b0;
            pend_idx_nxt   = cmp_idx_r;
            idx_nxt        = idx_r + 7'd1;
            state_nxt      = S_READ;
          end
        end else begin
          if (key_hit) begin
            pend_nxt     = 1'b1;
            pend_idx_nxt = cmp_idx_r;
          end
          idx_nxt   = idx_r + 7'd1;
          state_nxt = S_READ;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      slots_r     <= spst_pkg::CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        slots_r <= cfg_wr_data;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_tdata[1:0];
      home_r <= in_tdata[7:2];
      step_r <= in_tdata[13:8];
      key_r  <= in_tdata[14 +: KEY_BITS];
    end
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    cmp_vld_r    <= cmp_vld_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(spst_pkg::OUT_TDATA_W - spst_pkg::OUT_USED_W)'(0),
                       out_slot_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

@@ design/spst_checker.sv @@
`include "stepped_probe_slot_table_unit_assert.svh"

module spst_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [spst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);

  // A stalled result keeps its payload.
  `SPST_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // The block works on one item at a time, so it is busy right after an accept.
  `SPST_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "item accepted while busy")

  // Every status other than a match ends its item.
  `SPST_ASSERT_NOW(a_single_last, out_tvalid && (out_tdata[2:0] != spst_pkg::ST_MATCH), out_tlast, "single result without tlast")

  // No unused status code and no stray bits in the padding.
  `SPST_ASSERT_NOW(a_status_legal, out_tvalid, (out_tdata[2:0] != spst_pkg::ST_UNUSED) && (out_tdata[15:9] == 7'd0), "illegal result payload")

endmodule

bind stepped_probe_slot_table_unit spst_checker u_spst_checker (.*);

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spst_pkg::*;

  // One result item as it leaves the table: status, slot and the end-of-item mark.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] slot;
    logic       last;
  } result_t;

  // One row of the directed plan. A row either writes the slot count or sends one
  // item. Rows with want_typed set carry their result written out by hand; the
  // other rows are checked against the table predictor below.
  typedef struct packed {
    logic       cfg_write;
    logic [6:0] cfg_value;
    logic [1:0] op;
    logic [5:0] home;
    logic [5:0] step;
    logic [63:0] key;
    logic       want_typed;
    logic [2:0] want_status;
    logic [5:0] want_slot;
  } plan_row_t;

  localparam int QUIET_LIMIT = 2000;

  localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic [63:0] KEY_ALT_5 = 64'h5555_5555_5555_5555;
  localparam logic [63:0] KEY_MIX = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] KEY_REV = 64'hFEDC_BA98_7654_3210;

  // The directed plan starts from reset, where all 64 slots are active and empty.
  localparam int PLAN_LEN = 30;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // An empty table finds nothing, and removing an empty slot still reports it.
    '{1'b0, 7'd0, OP_FIND,   6'd0,  6'd0,  64'd0,     1'b1, ST_NOMATCH,  6'd0},
    '{1'b0, 7'd0, OP_REMOVE, 6'd0,  6'd0,  64'd0,     1'b1, ST_REMOVED,  6'd0},
    // The top slot, then a probe that runs off the end, then a zero step.
    '{1'b0, 7'd0, OP_INSERT, 6'd63, 6'd1,  KEY_ONES,  1'b1, ST_STORED,   6'd63},
    '{1'b0, 7'd0, OP_INSERT, 6'd63, 6'd1,  KEY_MIX,   1'b1, ST_DROPPED,  6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd63, 6'd0,  KEY_MIX,   1'b1, ST_DROPPED,  6'd0},
    // Slot zero, then the same key twice more through short probes.
    '{1'b0, 7'd0, OP_INSERT, 6'd0,  6'd63, 64'd0,     1'b1, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd0,  6'd1,  64'd0,     1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd0,  6'd2,  64'd0,     1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd1,  6'd63, KEY_MIX,   1'b0, ST_STORED,   6'd0},
    // Several matches for one key, then a single match.
    '{1'b0, 7'd0, OP_FIND,   6'd0,  6'd0,  64'd0,     1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_FIND,   6'd63, 6'd63, KEY_ONES,  1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_REMOVE, 6'd1,  6'd0,  64'd0,     1'b1, ST_REMOVED,  6'd1},
    '{1'b0, 7'd0, OP_FIND,   6'd0,  6'd0,  64'd0,     1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd0,  6'd1,  KEY_ALT_5, 1'b0, ST_STORED,   6'd0},
    // Clear empties everything; the hole left behind must not match.
    '{1'b0, 7'd0, OP_CLEAR,  6'd63, 6'd63, KEY_ALT_A, 1'b1, ST_CLEARED,  6'd0},
    '{1'b0, 7'd0, OP_FIND,   6'd0,  6'd0,  64'd0,     1'b1, ST_NOMATCH,  6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd42, 6'd21, KEY_ALT_A, 1'b1, ST_STORED,   6'd42},
    // A single active slot.
    '{1'b1, 7'd1, OP_INSERT, 6'd0,  6'd0,  64'd0,     1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd1,  6'd1,  KEY_ALT_5, 1'b1, ST_BADINDEX, 6'd1},
    '{1'b0, 7'd0, OP_INSERT, 6'd0,  6'd1,  KEY_ALT_5, 1'b1, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd0,  6'd1,  KEY_ALT_5, 1'b1, ST_DROPPED,  6'd0},
    '{1'b0, 7'd0, OP_FIND,   6'd0,  6'd0,  KEY_ALT_5, 1'b0, ST_STORED,   6'd0},
    // No active slots at all.
    '{1'b1, 7'd0, OP_INSERT, 6'd0,  6'd0,  64'd0,     1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd0,  6'd1,  KEY_ALT_5, 1'b1, ST_BADINDEX, 6'd0},
    '{1'b0, 7'd0, OP_REMOVE, 6'd63, 6'd0,  64'd0,     1'b1, ST_BADINDEX, 6'd63},
    '{1'b0, 7'd0, OP_FIND,   6'd0,  6'd0,  KEY_ALT_5, 1'b1, ST_NOMATCH,  6'd0},
    // Count above range saturates to 64; slot 42 survived the smaller settings.
    '{1'b1, 7'd127, OP_INSERT, 6'd0, 6'd0, 64'd0,     1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_INSERT, 6'd63, 6'd5,  KEY_REV,   1'b1, ST_STORED,   6'd63},
    '{1'b0, 7'd0, OP_FIND,   6'd0,  6'd0,  KEY_ALT_A, 1'b0, ST_STORED,   6'd0},
    '{1'b0, 7'd0, OP_REMOVE, 6'd42, 6'd0,  64'd0,     1'b1, ST_REMOVED,  6'd42}
  };

  // The random part runs in phases, each under its own slot count.
  localparam int PHASES = 9;
  localparam logic [6:0] PHASE_SLOTS [PHASES] = '{7'd64, 7'd16, 7'd127, 7'd5, 7'd0,
                                                  7'd1, 7'd40, 7'd2, 7'd64};
  localparam int PHASE_ITEMS [PHASES] = '{110, 50, 110, 40, 15, 25, 70, 30, 50};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // opcode [1:0], home_index [7:2], probe_step [13:8], key_value [77:14], zero [79:78]
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // status [2:0], slot_index [8:3], zero [15:9]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  stepped_probe_slot_table_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table. Keys are only ever read from slots marked in use,
  // and a slot is only marked in use by an insert that wrote its key.
  logic [63:0] shadow_keys [64];
  logic        shadow_used [64];
  int          active_slots = 64;

  result_t     pending_results [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  logic [9:0]  ready_phase = '0;
  logic [63:0] key_pool [6];

  function automatic result_t result_of(input logic [2:0] status, input logic [5:0] slot,
                                        input logic last);
    result_t r;
    r.status = status;
    r.slot   = slot;
    r.last   = last;
    return r;
  endfunction

  // Applies one operation to the shadow table and returns the results it causes.
  function automatic void table_op_results(input logic [1:0] op, input logic [5:0] home,
                                           input logic [5:0] step, input logic [63:0] key,
                                           output result_t res [$]);
    int slot;
    res = {};
    case (op)
      OP_INSERT: begin
        if (home >= active_slots) begin
          res.push_back(result_of(ST_BADINDEX, home, 1'b1));
        end else begin
          slot = home;
          if (shadow_used[slot]) begin
            // A zero step can never leave the occupied home slot.
            if (step == 6'd0) slot = active_slots;
            while (slot < active_slots && shadow_used[slot]) slot += step;
          end
          if (slot >= active_slots) begin
            res.push_back(result_of(ST_DROPPED, 6'd0, 1'b1));
          end else begin
            shadow_keys[slot] = key;
            shadow_used[slot] = 1'b1;
            res.push_back(result_of(ST_STORED, slot[5:0], 1'b1));
          end
        end
      end
      OP_REMOVE: begin
        if (home >= active_slots) begin
          res.push_back(result_of(ST_BADINDEX, home, 1'b1));
        end else begin
          shadow_used[home] = 1'b0;
          res.push_back(result_of(ST_REMOVED, home, 1'b1));
        end
      end
      OP_CLEAR: begin
        // Clear reaches every slot, including those beyond the active count.
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        res.push_back(result_of(ST_CLEARED, 6'd0, 1'b1));
      end
      default: begin
        for (int i = 0; i < active_slots; i++) begin
          if (shadow_used[i] && shadow_keys[i] == key) begin
            res.push_back(result_of(ST_MATCH, i[5:0], 1'b0));
          end
        end
        if (res.size() == 0) res.push_back(result_of(ST_NOMATCH, 6'd0, 1'b1));
        else res[res.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // Sends one item. The sender runs in bursts: when a burst is used up it drops
  // in_tvalid for a random gap (sometimes none) and draws a new burst length,
  // some of them long enough to give stretches with no idling at all.
  task automatic send_item(input logic [1:0] op, input logic [5:0] home,
                           input logic [5:0] step, input logic [63:0] key,
                           input logic typed, input result_t typed_res);
    result_t res [$];
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, key, step, home, op};
    do @(posedge clk); while (!in_tready);
    table_op_results(op, home, step, key, res);
    if (typed) pending_results.push_back(typed_res);
    else foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // Holds the input back until every result owed has been taken, then lets
  // the sequencer settle. Always waits on the clock before checking, so
  // in_tvalid is never lowered and raised in the same step.
  task automatic wait_table_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [6:0] value);
    wait_table_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    active_slots = (value > 7'd64) ? 64 : int'(value);
  endtask

  // The receiver cycles through four stall patterns in equal turns: always
  // ready, mostly ready, a fixed 3-of-8 duty pattern, and a coin toss.
  always @(posedge clk) begin
    ready_phase <= ready_phase + 10'd1;
    case (ready_phase[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (ready_phase[2:0] < 3'd3);
      default: out_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  // Every result is compared with the oldest one owed. Signals are read in the
  // active region of the edge, so they hold their values from before it.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_of(out_tdata[2:0], out_tdata[8:3], out_tlast);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d last %0d",
                 $time, got.status, got.slot, got.last);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected status %0d slot %0d last %0d, actual status %0d slot %0d last %0d",
                   $time, want.status, want.slot, want.last, got.status, got.slot, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Counts cycles in which neither channel nor the register port moves anything.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  initial begin
    logic [1:0]  op;
    logic [5:0]  home;
    logic [5:0]  step;
    logic [63:0] key;
    int          pick;
    int          home_top;

    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_keys[i] = '0;
    end
    // A small pool of keys makes finds with several matches common.
    key_pool[0] = '0;
    key_pool[1] = KEY_ONES;
    for (int i = 2; i < 6; i++) key_pool[i] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[r]) begin
      if (PLAN[r].cfg_write) begin
        write_slot_count(PLAN[r].cfg_value);
      end else begin
        send_item(PLAN[r].op, PLAN[r].home, PLAN[r].step, PLAN[r].key, PLAN[r].want_typed,
                  result_of(PLAN[r].want_status, PLAN[r].want_slot, 1'b1));
      end
    end

    // Random part. Inserts outweigh removes so the table fills up and probes
    // get long; homes crowd into the low quarter now and then to force
    // collisions, and a few homes fall anywhere so bad indexes keep coming.
    for (int p = 0; p < PHASES; p++) begin
      write_slot_count(PHASE_SLOTS[p]);
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 52) op = OP_INSERT;
        else if (pick < 72) op = OP_FIND;
        else if (pick < 97) op = OP_REMOVE;
        else op = OP_CLEAR;
        if (active_slots == 0 || $urandom_range(0, 9) == 0) begin
          home = 6'($urandom_range(0, 63));
        end else begin
          home_top = ($urandom_range(0, 1) == 0) ? (active_slots - 1) / 4 : active_slots - 1;
          home = 6'($urandom_range(0, home_top));
        end
        step = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(1, 4)) : 6'($urandom_range(0, 63));
        key  = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 5)] : {$urandom, $urandom};
        send_item(op, home, step, key, 1'b0, result_of(ST_STORED, 6'd0, 1'b0));
        // Now and then the sender waits for the table to drain completely.
        if ($urandom_range(0, 59) == 0) wait_table_idle();
      end
    end

    // Let everything owed arrive, then watch a while longer for strays.
    wait_table_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
